// ----- rtl/core/acg_pkg.sv -----
// Package for the anagram group classifier: field widths, parameter defaults and
// the sequencer state type. No dependencies.

package acg_pkg;

	localparam int SYMBOL_W          = 8;
	localparam int GROUP_INDEX_W     = 6;
	localparam int SYMBOL_CODES      = 256;

	localparam int MAX_GROUPS_DEF    = 64;
	localparam int MAX_LENGTH_DEF    = 255;
	localparam int ALPHABET_SIZE_DEF = 256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_END,
		ST_CMP,
		ST_NEW,
		ST_OUT
	} acg_state_t;

endpackage

// ----- rtl/core/acg_in_if.sv -----
// Request channel of the anagram group classifier: one character per request.
// Depends on acg_pkg.

interface acg_in_if;
	logic                          valid;
	logic                          ready;
	logic [acg_pkg::SYMBOL_W-1:0]  symbol;
	logic                          symbol_present;
	logic                          last;

	modport source(output valid, symbol, symbol_present, last, input ready);
	modport sink(input valid, symbol, symbol_present, last, output ready);
endinterface

// ----- rtl/core/acg_out_if.sv -----
// Result channel of the anagram group classifier: one request per finished string.
// Depends on acg_pkg.

interface acg_out_if;
	logic                               valid;
	logic                               ready;
	logic [acg_pkg::GROUP_INDEX_W-1:0]  group_index;
	logic                               new_group;
	logic                               table_full;
	logic                               too_long;

	modport source(output valid, group_index, new_group, table_full, too_long, input ready);
	modport sink(input valid, group_index, new_group, table_full, too_long, output ready);
endinterface

// ----- rtl/core/anagram_group_classifier.sv -----
// Anagram group classifier top level: histogram memory, group key memories and
// the compare/copy sequencer. Depends on acg_pkg, acg_in_if and acg_out_if.
//
// Usage:
//   chars   : one request per character (symbol, symbol_present, last). A request
//             with symbol_present low carries no character; with last high it ends
//             the string, with last low it does nothing.
//   results : one request per string end: group_index, new_group, table_full,
//             too_long.
// Sequence:
//   A character is read in ST_IDLE and its count written back in ST_UPD (the
//   count memory read is registered). A string end passes the decision state
//   ST_END, then walks the stored groups through one shared compare unit: a
//   group that matches is read through all entries, a group that differs is
//   dropped at its first differing entry. Opening a group copies the histogram
//   into the group memories. ST_OUT then loads the result register.
//   chars.ready is high only while the sequencer idles.
// Reset: arst_n clears the sequencer, the group count, the working length and
//   the count valid bits; the group memories need no clearing pass.
// Stall: the result register holds a finished result while results.ready is
//   low; the next string is accepted meanwhile and only its end waits.

module anagram_group_classifier #(
	parameter int MAX_GROUPS    = acg_pkg::MAX_GROUPS_DEF,
	parameter int MAX_LENGTH    = acg_pkg::MAX_LENGTH_DEF,
	parameter int ALPHABET_SIZE = acg_pkg::ALPHABET_SIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	acg_in_if.sink       chars,
	acg_out_if.source    results
);

	localparam int LW  = $clog2(MAX_LENGTH + 1);               // count and length width
	localparam int CW  = $clog2(ALPHABET_SIZE);                // character index width
	localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GW  = $clog2(MAX_GROUPS + 1);               // group count width
	localparam int HD  = MAX_GROUPS * ALPHABET_SIZE;           // group histogram depth
	localparam int HW  = (HD > 1) ? $clog2(HD) : 1;

	acg_pkg::acg_state_t state_q, state_d;

	// Symbol wrap onto the alphabet, built at elaboration.
	logic [CW-1:0] wrap_tab [acg_pkg::SYMBOL_CODES];
	for (genvar i = 0; i < acg_pkg::SYMBOL_CODES; i++) begin : g_wrap
		assign wrap_tab[i] = CW'(i % ALPHABET_SIZE);
	end

	// Working string state.
	logic [CW-1:0]            sym_q;
	logic                     present_q;
	logic                     last_q;
	logic [LW-1:0]            len_q;
	logic                     ovf_q;
	logic [ALPHABET_SIZE-1:0] cval_q;

	// Group table state and walk counters.
	logic [GW-1:0]  groups_q;
	logic [GIW-1:0] g_q;
	logic [HW-1:0]  base_q;
	logic [CW-1:0]  c_q;
	logic           done_q;
	logic           cmp_v_s1;
	logic [CW-1:0]  idx_s1;

	// Pending result and result register.
	logic [GIW-1:0] res_idx_q;
	logic           res_new_q;
	logic           res_full_q;
	logic           res_long_q;
	logic           out_v_q;
	logic [acg_pkg::GROUP_INDEX_W-1:0] out_idx_q;
	logic           out_new_q;
	logic           out_full_q;
	logic           out_long_q;

	// Memories.
	logic [LW-1:0] cnt_mem  [ALPHABET_SIZE];
	logic [LW-1:0] hist_mem [HD];
	logic [LW-1:0] glen_mem [MAX_GROUPS];
	logic [LW-1:0] cnt_rd;
	logic          cval_rd;
	logic [LW-1:0] hist_rd;
	logic [LW-1:0] glen_rd;

	// Control from the output decode.
	logic          chars_take;
	logic          cnt_we;
	logic [CW-1:0] cnt_ra;
	logic [LW-1:0] cnt_wd;
	logic [HW-1:0] hist_ra;
	logic [HW-1:0] hist_wa;
	logic          hist_we;
	logic          glen_we;
	logic          issue;
	logic          load_out;

	// Shared compare unit.
	logic [LW-1:0] cnt_val;
	logic          mismatch;
	logic          cmp_last;
	logic          grp_last;
	logic          tab_full;
	logic          counted;

	assign cnt_val  = cval_rd ? cnt_rd : '0;
	assign mismatch = cmp_v_s1 && ((hist_rd != cnt_val) || (glen_rd != len_q));
	assign cmp_last = cmp_v_s1 && (idx_s1 == CW'(ALPHABET_SIZE - 1));
	assign grp_last = ((GW'(g_q) + GW'(1)) == groups_q);
	assign tab_full = (groups_q == GW'(MAX_GROUPS));
	assign counted  = present_q && (len_q < LW'(MAX_LENGTH));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			acg_pkg::ST_IDLE: begin
				if (chars.valid) state_d = acg_pkg::ST_UPD;
			end
			acg_pkg::ST_UPD: begin
				state_d = last_q ? acg_pkg::ST_END : acg_pkg::ST_IDLE;
			end
			acg_pkg::ST_END: begin
				if (ovf_q) state_d = acg_pkg::ST_OUT;
				else if (groups_q == '0) state_d = acg_pkg::ST_NEW;
				else state_d = acg_pkg::ST_CMP;
			end
			acg_pkg::ST_CMP: begin
				if (mismatch) begin
					if (grp_last) state_d = tab_full ? acg_pkg::ST_OUT : acg_pkg::ST_NEW;
				end else if (cmp_last) begin
					state_d = acg_pkg::ST_OUT;
				end
			end
			acg_pkg::ST_NEW: begin
				if (cmp_last) state_d = acg_pkg::ST_OUT;
			end
			acg_pkg::ST_OUT: begin
				if (!out_v_q || results.ready) state_d = acg_pkg::ST_IDLE;
			end
			default: state_d = acg_pkg::ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		chars_take = 1'b0;
		cnt_we     = 1'b0;
		hist_we    = 1'b0;
		glen_we    = 1'b0;
		issue      = 1'b0;
		load_out   = 1'b0;
		cnt_ra     = c_q;
		unique case (state_q)
			acg_pkg::ST_IDLE: begin
				chars_take = chars.valid;
				cnt_ra     = wrap_tab[chars.symbol];
			end
			acg_pkg::ST_UPD: begin
				cnt_we = counted;
			end
			acg_pkg::ST_END: begin
			end
			acg_pkg::ST_CMP: begin
				issue = !mismatch && !done_q;
			end
			acg_pkg::ST_NEW: begin
				issue   = !done_q;
				hist_we = cmp_v_s1;
				glen_we = 1'b1;
			end
			acg_pkg::ST_OUT: begin
				load_out = !out_v_q || results.ready;
			end
			default: begin
			end
		endcase
	end

	assign cnt_wd  = cnt_val + LW'(1);
	assign hist_ra = base_q + HW'(c_q);
	assign hist_wa = base_q + HW'(idx_s1);

	assign chars.ready         = (state_q == acg_pkg::ST_IDLE);
	assign results.valid       = out_v_q;
	assign results.group_index = out_idx_q;
	assign results.new_group   = out_new_q;
	assign results.table_full  = out_full_q;
	assign results.too_long    = out_long_q;

	// Memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[sym_q] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_wa] <= cnt_val;
		hist_rd <= hist_mem[hist_ra];
	end

	always_ff @(posedge clk) begin
		if (glen_we) glen_mem[GIW'(groups_q)] <= len_q;
		glen_rd <= glen_mem[g_q];
	end

	// Valid bits of the count memory read with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cval_rd <= 1'b0;
		end else begin
			cval_rd <= cval_q[cnt_ra];
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= acg_pkg::ST_IDLE;
			present_q <= 1'b0;
			last_q    <= 1'b0;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			cval_q    <= '0;
			groups_q  <= '0;
			done_q    <= 1'b0;
			cmp_v_s1  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// Capture a character request.
			if (chars_take) begin
				present_q <= chars.symbol_present;
				last_q    <= chars.last;
			end

			// Count the character or mark the string too long.
			if (state_q == acg_pkg::ST_UPD && present_q) begin
				if (counted) begin
					cval_q[sym_q] <= 1'b1;
					len_q         <= len_q + LW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end

			// Start the group walk.
			if (state_q == acg_pkg::ST_END) begin
				done_q   <= 1'b0;
				cmp_v_s1 <= 1'b0;
			end

			// Advance the entry walk, or drop the group on a mismatch.
			if (state_q == acg_pkg::ST_CMP || state_q == acg_pkg::ST_NEW) begin
				if (state_q == acg_pkg::ST_CMP && mismatch) begin
					cmp_v_s1 <= 1'b0;
					done_q   <= 1'b0;
				end else if (issue) begin
					cmp_v_s1 <= 1'b1;
					done_q   <= (c_q == CW'(ALPHABET_SIZE - 1));
				end else begin
					cmp_v_s1 <= 1'b0;
				end
			end

			if (state_q == acg_pkg::ST_NEW && cmp_last) groups_q <= groups_q + GW'(1);

			// Load the result register and clear the working string.
			if (load_out) begin
				out_v_q <= 1'b1;
				cval_q  <= '0;
				len_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (chars_take) sym_q <= wrap_tab[chars.symbol];

		if (state_q == acg_pkg::ST_END) begin
			g_q        <= '0;
			base_q     <= '0;
			c_q        <= '0;
			res_idx_q  <= '0;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
			res_long_q <= ovf_q;
		end

		if (state_q == acg_pkg::ST_CMP) begin
			if (mismatch) begin
				g_q    <= g_q + GIW'(1);
				base_q <= base_q + HW'(ALPHABET_SIZE);
				c_q    <= '0;
				if (grp_last && tab_full) res_full_q <= 1'b1;
			end else begin
				if (issue) begin
					c_q    <= c_q + CW'(1);
					idx_s1 <= c_q;
				end
				if (cmp_last) res_idx_q <= g_q;
			end
		end

		if (state_q == acg_pkg::ST_NEW) begin
			if (issue) begin
				c_q    <= c_q + CW'(1);
				idx_s1 <= c_q;
			end
			if (cmp_last) begin
				res_idx_q <= GIW'(groups_q);
				res_new_q <= 1'b1;
			end
		end

		if (load_out) begin
			out_idx_q  <= acg_pkg::GROUP_INDEX_W'(res_idx_q);
			out_new_q  <= res_new_q;
			out_full_q <= res_full_q;
			out_long_q <= res_long_q;
		end
	end

endmodule
